[sv/fibonacci_lsb_stego_codec_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Fibonacci LSB stego codec checker
// Clocked, reset-gated property macros used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_LSB_STEGO_CODEC_DEFINES_SVH
`define FIBONACCI_LSB_STEGO_CODEC_DEFINES_SVH

// Same-cycle implication: when a holds, c holds at this edge.
`define FLS_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error(msg);

// Next-cycle implication: when a holds, c holds at the following edge.
`define FLS_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error(msg);

`endif

[sv/fls_pkg.sv]
// ----------------------------------------------------------------------------
// Fibonacci LSB stego codec package
// Shared types, register indexes and the hidden-bit lookup table.
// ----------------------------------------------------------------------------
package fls_pkg;

	typedef logic [7:0] pixel_t;
	typedef logic [7:0] msg_byte_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_MODE           = 1'b0,
		REG_MESSAGE_LENGTH = 1'b1
	} reg_index_t;

	localparam int CFG_DATA_W  = 32;
	localparam int ZECK_COUNT  = 12;
	localparam logic MODE_HIDE = 1'b0;

	localparam logic [7:0] ZECK_TERMS [ZECK_COUNT] =
		'{8'd1, 8'd2, 8'd3, 8'd5, 8'd8, 8'd13, 8'd21, 8'd34, 8'd55, 8'd89,
		  8'd144, 8'd233};

	// Greedy Zeckendorf decomposition: is the term 1 used?
	function automatic logic zeck_low_term(input int v);
		int   rest;
		logic skip;
		logic res;
		rest = v;
		skip = 1'b0;
		res  = 1'b0;
		for (int k = ZECK_COUNT - 1; k >= 0; k--) begin
			if (skip) begin
				skip = 1'b0;
			end else if (int'(ZECK_TERMS[k]) <= rest) begin
				rest = rest - int'(ZECK_TERMS[k]);
				if (k == 0) begin
					res = 1'b1;
				end
				skip = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic logic [255:0] build_hidden_lut();
		logic [255:0] lut;
		lut = '0;
		for (int v = 0; v < 256; v++) begin
			lut[v] = zeck_low_term(v);
		end
		return lut;
	endfunction

	// Hidden bit of every pixel value, worked out at elaboration
	localparam logic [255:0] HIDDEN_LUT = build_hidden_lut();

endpackage

[sv/fibonacci_lsb_stego_codec.sv]
// ----------------------------------------------------------------------------
// Fibonacci LSB stego codec
// Hides a length header and message bytes in the Zeckendorf low term of
// pixels, or pulls them back out, one pixel per item.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------
// input    | in_valid / in_stall       | pixel, message_byte
// result   | res_valid / res_stall     | pixel_out, byte_taken, out_byte,
//          |                           | out_valid, last_byte
// config   | cfg_write                 | cfg_index, cfg_data
//
// One item per cycle sustained while res_stall stays low; each item passes
// through the input register, then the result register, to its result.
// The codec state (header count, byte counter, bit position) updates in the
// cycle the item moves from the input register into the result register.
// Reset clears the handshake flags and the codec state; it takes effect at once.
// A stalled result holds the input register; in_stall rises only when both
// registers are full and res_stall is high.
// ----------------------------------------------------------------------------
module fibonacci_lsb_stego_codec #(
	parameter int HEADER_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_write,
	input  fls_pkg::reg_index_t                cfg_index,
	input  logic [fls_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input items
	input  logic                               in_valid,
	output logic                               in_stall,
	input  fls_pkg::pixel_t                    pixel,
	input  fls_pkg::msg_byte_t                 message_byte,
	// result items
	output logic                               res_valid,
	input  logic                               res_stall,
	output fls_pkg::pixel_t                    pixel_out,
	output logic                               byte_taken,
	output fls_pkg::msg_byte_t                 out_byte,
	output logic                               out_valid,
	output logic                               last_byte
);
	import fls_pkg::*;

	localparam int HCW = $clog2(HEADER_BITS + 1);
	localparam int HIW = $clog2(HEADER_BITS);

	// configuration registers
	logic                  mode_q;
	logic [CFG_DATA_W-1:0] message_length_q;

	// codec state
	logic [HCW-1:0]         header_count_q, header_count_d;
	logic [HEADER_BITS-1:0] header_shift_q, header_shift_d;
	logic [31:0]            bytes_left_q, bytes_left_d;
	logic [2:0]             bit_position_q, bit_position_d;
	logic [7:0]             byte_register_q, byte_register_d;
	logic                   byte_loaded_q, byte_loaded_d;

	// input register
	logic      valid_s1;
	pixel_t    pixel_s1;
	msg_byte_t message_byte_s1;

	// result register
	logic      res_valid_q;
	pixel_t    pixel_out_q;
	logic      byte_taken_q;
	msg_byte_t out_byte_q;
	logic      out_valid_q;
	logic      last_byte_q;

	// per-item results
	pixel_t    pixel_out_d;
	logic      byte_taken_d;
	msg_byte_t out_byte_d;
	logic      out_valid_d;
	logic      last_byte_d;

	logic       advance;
	logic       accept;
	logic       hidden;
	logic       embed_bit;
	pixel_t     embedded;
	logic [HIW-1:0]         hdr_idx;
	logic [HEADER_BITS-1:0] hdr_field;
	logic [HCW-1:0]         hc_inc;
	logic [7:0]             body_byte;
	logic [7:0]             shifted_byte;

	// The input register moves on whenever the result register is free or drained.
	assign advance  = !res_valid_q || !res_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_HIDE;
			message_length_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MODE:           mode_q <= cfg_data[0];
				REG_MESSAGE_LENGTH: message_length_q <= cfg_data;
				default:            mode_q <= mode_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// item datapath
	// ------------------------------------------------------------------
	assign hidden    = HIDDEN_LUT[pixel_s1];
	assign hdr_field = message_length_q[HEADER_BITS-1:0];
	// Header bits go out MSB first; only meaningful while the header runs.
	assign hdr_idx   = HIW'(HEADER_BITS - 1) - header_count_q[HIW-1:0];
	assign hc_inc    = header_count_q + HCW'(1);
	// Use the held byte, or latch the offered one on the first body bit.
	assign body_byte    = byte_loaded_q ? byte_register_q : message_byte_s1;
	assign shifted_byte = {byte_register_q[6:0], hidden};

	always_comb begin
		if (header_count_q < HCW'(HEADER_BITS)) begin
			embed_bit = hdr_field[hdr_idx];
		end else begin
			embed_bit = body_byte[3'd7 - bit_position_q];
		end
	end

	fls_nearest u_nearest (
		.pixel     (pixel_s1),
		.target    (embed_bit),
		.pixel_out (embedded)
	);

	always_comb begin
		header_count_d  = header_count_q;
		header_shift_d  = header_shift_q;
		bytes_left_d    = bytes_left_q;
		bit_position_d  = bit_position_q;
		byte_register_d = byte_register_q;
		byte_loaded_d   = byte_loaded_q;
		pixel_out_d     = pixel_s1;
		byte_taken_d    = 1'b0;
		out_byte_d      = '0;
		out_valid_d     = 1'b0;
		last_byte_d     = 1'b0;

		if (header_count_q < HCW'(HEADER_BITS)) begin
			// header phase
			if (mode_q == MODE_HIDE) begin
				pixel_out_d = embedded;
			end else begin
				header_shift_d = {header_shift_q[HEADER_BITS-2:0], hidden};
			end
			header_count_d = hc_inc;
			if (hc_inc == HCW'(HEADER_BITS)) begin
				// header complete: load the byte count and start a fresh byte
				bytes_left_d    = (mode_q == MODE_HIDE) ? 32'(hdr_field)
				                                        : 32'(header_shift_d);
				bit_position_d  = '0;
				byte_register_d = '0;
				byte_loaded_d   = 1'b0;
			end
		end else if (bytes_left_q != '0) begin
			if (mode_q == MODE_HIDE) begin
				pixel_out_d     = embedded;
				byte_taken_d    = !byte_loaded_q;
				byte_register_d = body_byte;
				byte_loaded_d   = 1'b1;
				if (bit_position_q == 3'd7) begin
					bit_position_d = '0;
					byte_loaded_d  = 1'b0;
					bytes_left_d   = bytes_left_q - 32'd1;
				end else begin
					bit_position_d = bit_position_q + 3'd1;
				end
			end else begin
				byte_register_d = shifted_byte;
				if (bit_position_q == 3'd7) begin
					out_byte_d      = shifted_byte;
					out_valid_d     = 1'b1;
					last_byte_d     = (bytes_left_q == 32'd1);
					byte_register_d = '0;
					bit_position_d  = '0;
					bytes_left_d    = bytes_left_q - 32'd1;
				end else begin
					bit_position_d = bit_position_q + 3'd1;
				end
			end
		end
		// message done: pass through, all flags low
	end

	// ------------------------------------------------------------------
	// input register: load when empty, even while the result is stalled
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1        <= pixel;
			message_byte_s1 <= message_byte;
		end
	end

	// ------------------------------------------------------------------
	// codec state: advance once per item leaving the input register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q  <= '0;
			header_shift_q  <= '0;
			bytes_left_q    <= '0;
			bit_position_q  <= '0;
			byte_register_q <= '0;
			byte_loaded_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			header_count_q  <= header_count_d;
			header_shift_q  <= header_shift_d;
			bytes_left_q    <= bytes_left_d;
			bit_position_q  <= bit_position_d;
			byte_register_q <= byte_register_d;
			byte_loaded_q   <= byte_loaded_d;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			pixel_out_q  <= pixel_out_d;
			byte_taken_q <= byte_taken_d;
			out_byte_q   <= out_byte_d;
			out_valid_q  <= out_valid_d;
			last_byte_q  <= last_byte_d;
		end
	end

	assign res_valid  = res_valid_q;
	assign pixel_out  = pixel_out_q;
	assign byte_taken = byte_taken_q;
	assign out_byte   = out_byte_q;
	assign out_valid  = out_valid_q;
	assign last_byte  = last_byte_q;

endmodule

[sv/fls_nearest.sv]
// ----------------------------------------------------------------------------
// Nearest pixel with a given hidden bit
// Searches p, p+1, p-1, p+2, p-2 in that order and returns the first hit.
// ----------------------------------------------------------------------------
module fls_nearest (
	input  fls_pkg::pixel_t pixel,
	input  logic            target,
	output fls_pkg::pixel_t pixel_out
);
	import fls_pkg::*;

	logic ok_p0, ok_p1, ok_m1, ok_p2, ok_m2;

	assign ok_p0 = (HIDDEN_LUT[pixel] == target);
	assign ok_p1 = (pixel <= 8'd254) && (HIDDEN_LUT[pixel + 8'd1] == target);
	assign ok_m1 = (pixel >= 8'd1) && (HIDDEN_LUT[pixel - 8'd1] == target);
	assign ok_p2 = (pixel <= 8'd253) && (HIDDEN_LUT[pixel + 8'd2] == target);
	assign ok_m2 = (pixel >= 8'd2) && (HIDDEN_LUT[pixel - 8'd2] == target);

	always_comb begin
		if (ok_p0) begin
			pixel_out = pixel;
		end else if (ok_p1) begin
			pixel_out = pixel + 8'd1;
		end else if (ok_m1) begin
			pixel_out = pixel - 8'd1;
		end else if (ok_p2) begin
			pixel_out = pixel + 8'd2;
		end else if (ok_m2) begin
			pixel_out = pixel - 8'd2;
		end else begin
			pixel_out = pixel;
		end
	end

endmodule

[sv/fls_checker.sv]
// ----------------------------------------------------------------------------
// Fibonacci LSB stego codec port checker
// Watches the top-level ports and flags handshake or result inconsistencies.
// ----------------------------------------------------------------------------
`include "fibonacci_lsb_stego_codec_defines.svh"

module fls_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic res_valid,
	input logic res_stall,
	input logic byte_taken,
	input logic out_valid,
	input logic last_byte
);

	// a stalled result stays offered
	`FLS_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid, "result dropped")

	// an empty result register never backs up the input
	`FLS_ASSERT_IMP(a_no_stall_empty, clk, arst_n, !res_valid, !in_stall, "stall while empty")

	// a byte is never latched and emitted in the same item
	`FLS_ASSERT_IMP(a_mode_excl, clk, arst_n, res_valid, !(byte_taken && out_valid), "both flags")

	// the final flag only comes with an emitted byte
	`FLS_ASSERT_IMP(a_last_valid, clk, arst_n, res_valid && last_byte, out_valid, "stray last")

	// a stall only arises when items are waiting
	`FLS_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, res_valid && res_stall, "bad stall")

endmodule

bind fibonacci_lsb_stego_codec fls_checker u_fls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.byte_taken (byte_taken),
	.out_valid  (out_valid),
	.last_byte  (last_byte)
);

[sim/fibonacci_lsb_stego_codec_test.sv]
// ----------------------------------------------------------------------------
// Fibonacci LSB stego codec testbench
// Drives pixels through the codec with random sender gaps and receiver stalls.
// A scoreboard class tracks the codec state itself and checks every result.
// The single length header is built in mixed hide and extract phases. The
// message body then runs in random bursts of either mode until it is done,
// and a pass-through tail follows.
// ----------------------------------------------------------------------------
module fibonacci_lsb_stego_codec_test;
	import fls_pkg::*;

	localparam int   HEADER_LEN   = 32;
	localparam logic MODE_EXTRACT = ~MODE_HIDE;
	localparam int   TAIL_ITEMS   = 48;

	// Cover pixels for the opening header bits: range ends and the
	// neighbors of the larger Fibonacci terms.
	localparam pixel_t HIDE_HDR_PIX [8] =
		'{8'd0, 8'd255, 8'd1, 8'd254, 8'd2, 8'd253, 8'd128, 8'd233};
	localparam pixel_t EXTR_HDR_PIX [12] =
		'{8'd255, 8'd0, 8'd1, 8'd254, 8'd89, 8'd88, 8'd144, 8'd143,
		  8'd232, 8'd233, 8'd34, 8'd35};

	// ------------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the codec registers and state, works
	// out the result of each accepted pixel and checks results in order.
	// ------------------------------------------------------------------------
	class stego_codec_model #(int HDR_BITS = 32);
		typedef struct packed {
			logic [7:0] pixel_out;
			logic       byte_taken;
			logic [7:0] out_byte;
			logic       out_valid;
			logic       last_byte;
		} codec_out_t;

		logic        mode_q;
		logic [31:0] msg_len_q;
		int unsigned hdr_count;
		logic [31:0] hdr_shift;
		logic [31:0] bytes_left;
		logic [2:0]  bit_pos;
		logic [7:0]  byte_reg;
		logic        byte_loaded;
		codec_out_t  awaited[$];
		int unsigned items_taken;
		int unsigned results_seen;
		int unsigned mismatch_count;

		function new();
			mode_q         = MODE_HIDE;
			msg_len_q      = '0;
			hdr_count      = 0;
			hdr_shift      = '0;
			bytes_left     = '0;
			bit_pos        = '0;
			byte_reg       = '0;
			byte_loaded    = 1'b0;
			items_taken    = 0;
			results_seen   = 0;
			mismatch_count = 0;
		endfunction

		function logic [31:0] hdr_mask();
			logic [63:0] span;
			span = (64'd1 << HDR_BITS) - 64'd1;
			return span[31:0];
		endfunction

		// Greedy Zeckendorf walk from 233 down to 2; whatever is left (0 or 1)
		// says whether the term 1 is needed.
		function logic zeck_one(logic [7:0] v);
			int unsigned rest;
			int unsigned fib_hi;
			int unsigned fib_lo;
			int unsigned t;
			rest   = v;
			fib_hi = 233;
			fib_lo = 144;
			while (fib_hi >= 2) begin
				if (rest >= fib_hi) begin
					rest -= fib_hi;
				end
				t      = fib_hi - fib_lo;
				fib_hi = fib_lo;
				fib_lo = t;
			end
			return rest == 1;
		endfunction

		// Closest value carrying bit b; on a tie the upper value wins.
		function logic [7:0] nearest_carrier(logic [7:0] p, logic b);
			int pv;
			int up;
			int dn;
			pv = p;
			for (int d = 0; d <= 2; d++) begin
				up = pv + d;
				dn = pv - d;
				if (up <= 255 && zeck_one(up[7:0]) == b) begin
					return up[7:0];
				end
				if (dn >= 0 && zeck_one(dn[7:0]) == b) begin
					return dn[7:0];
				end
			end
			return p;
		endfunction

		function void set_reg(reg_index_t idx, logic [31:0] data);
			if (idx == REG_MODE) begin
				mode_q = data[0];
			end else begin
				msg_len_q = data;
			end
		endfunction

		function void take_pixel(logic [7:0] p, logic [7:0] mb);
			codec_out_t r;
			logic       b;
			r.pixel_out  = p;
			r.byte_taken = 1'b0;
			r.out_byte   = '0;
			r.out_valid  = 1'b0;
			r.last_byte  = 1'b0;
			items_taken++;
			if (hdr_count < HDR_BITS) begin
				if (mode_q == MODE_HIDE) begin
					b           = msg_len_q[HDR_BITS - 1 - hdr_count];
					r.pixel_out = nearest_carrier(p, b);
				end else begin
					hdr_shift = ((hdr_shift << 1) | 32'(zeck_one(p))) & hdr_mask();
				end
				hdr_count++;
				if (hdr_count >= HDR_BITS) begin
					hdr_count   = HDR_BITS;
					bytes_left  = (mode_q == MODE_HIDE) ? (msg_len_q & hdr_mask()) : hdr_shift;
					bit_pos     = '0;
					byte_reg    = '0;
					byte_loaded = 1'b0;
				end
			end else if (bytes_left != 0) begin
				if (mode_q == MODE_HIDE) begin
					if (!byte_loaded) begin
						byte_reg     = mb;
						byte_loaded  = 1'b1;
						r.byte_taken = 1'b1;
					end
					b           = byte_reg[3'd7 - bit_pos];
					r.pixel_out = nearest_carrier(p, b);
					if (bit_pos == 3'd7) begin
						bit_pos     = '0;
						byte_loaded = 1'b0;
						bytes_left--;
					end else begin
						bit_pos++;
					end
				end else begin
					byte_reg = {byte_reg[6:0], zeck_one(p)};
					if (bit_pos == 3'd7) begin
						r.out_byte  = byte_reg;
						r.out_valid = 1'b1;
						r.last_byte = (bytes_left == 1);
						byte_reg    = '0;
						bit_pos     = '0;
						bytes_left--;
					end else begin
						bit_pos++;
					end
				end
			end
			awaited.push_back(r);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch at result %0d, %s: got %0h, want %0h",
				results_seen, what, got, want);
			mismatch_count++;
		endtask

		task check_result(logic [7:0] pix, logic taken, logic [7:0] obyte,
				logic ovalid, logic olast);
			codec_out_t want;
			results_seen++;
			if (awaited.size() == 0) begin
				report_mismatch("result with nothing outstanding", 32'(pix), '0);
				return;
			end
			want = awaited.pop_front();
			if (pix !== want.pixel_out) begin
				report_mismatch("pixel_out", 32'(pix), 32'(want.pixel_out));
			end
			if (taken !== want.byte_taken) begin
				report_mismatch("byte_taken", 32'(taken), 32'(want.byte_taken));
			end
			if (obyte !== want.out_byte) begin
				report_mismatch("out_byte", 32'(obyte), 32'(want.out_byte));
			end
			if (ovalid !== want.out_valid) begin
				report_mismatch("out_valid", 32'(ovalid), 32'(want.out_valid));
			end
			if (olast !== want.last_byte) begin
				report_mismatch("last_byte", 32'(olast), 32'(want.last_byte));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	reg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	pixel_t                pixel;
	msg_byte_t             message_byte;
	logic                  res_valid;
	logic                  res_stall;
	pixel_t                pixel_out;
	logic                  byte_taken;
	msg_byte_t             out_byte;
	logic                  out_valid;
	logic                  last_byte;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	stego_codec_model #(HEADER_LEN) codec_model;

	fibonacci_lsb_stego_codec #(
		.HEADER_BITS(HEADER_LEN)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel       (pixel),
		.message_byte(message_byte),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.pixel_out   (pixel_out),
		.byte_taken  (byte_taken),
		.out_byte    (out_byte),
		.out_valid   (out_valid),
		.last_byte   (last_byte)
	);

	always #1 clk = ~clk;

	// Bias toward the range ends, where the carrier search is clipped.
	function automatic pixel_t rand_pixel();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick < 3) begin
			return pixel_t'(pick);
		end
		if (pick < 6) begin
			return pixel_t'(250 + pick);
		end
		return pixel_t'($urandom_range(0, 255));
	endfunction

	// Idle mix by progress: sender light and receiver heavy first, then the
	// reverse, then full rate on both sides.
	function automatic void pick_profile();
		if (codec_model.items_taken < 600) begin
			send_idle_pct  = 8;
			recv_stall_pct = 72;
		end else if (codec_model.items_taken < 1200) begin
			send_idle_pct  = 72;
			recv_stall_pct = 8;
		end else begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
	endfunction

	// Entered and left just after a falling edge. Keep valid high across
	// back-to-back items; drop it only for a random gap.
	task automatic push_pixel(pixel_t p, msg_byte_t mb);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		pixel        <= p;
		message_byte <= mb;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		codec_model.take_pixel(p, mb);
		@(negedge clk);
	endtask

	// Hold off the sender until every outstanding result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (codec_model.awaited.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// One register write; cfg_write drops and the task idles before returning, so writes never collide.
	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		codec_model.set_reg(idx, data);
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: draw a fresh stall decision every cycle.
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Check each result at the edge where it is taken.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			codec_model.check_result(pixel_out, byte_taken, out_byte, out_valid, last_byte);
		end
	end

	// Guard against a hung handshake.
	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned burst;
		logic        next_mode;

		codec_model    = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = REG_MODE;
		cfg_data       = '0;
		in_valid       = 1'b0;
		pixel          = '0;
		message_byte   = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		pick_profile();

		// Header, first bits: hide with an all-ones length at the pixel extremes.
		write_reg(REG_MODE, 32'(MODE_HIDE));
		write_reg(REG_MESSAGE_LENGTH, '1);
		for (int i = 0; i < 8; i++) begin
			push_pixel(HIDE_HDR_PIX[i], i[0] ? 8'hFF : 8'h00);
		end
		settle();

		// Switch to extract partway through the header; junk in the upper
		// data bits must not disturb the mode bit.
		write_reg(REG_MODE, ($urandom() & ~32'd1) | 32'(MODE_EXTRACT));
		for (int i = 0; i < 12; i++) begin
			push_pixel(EXTR_HDR_PIX[i], msg_byte_t'($urandom_range(0, 255)));
		end
		settle();

		// Back to hide with a zero length: these header bits are all zero.
		write_reg(REG_MODE, 32'(MODE_HIDE));
		write_reg(REG_MESSAGE_LENGTH, '0);
		repeat (8) push_pixel(rand_pixel(), msg_byte_t'($urandom_range(0, 255)));
		settle();

		// Close the header in hide mode so the body length is set here.
		write_reg(REG_MESSAGE_LENGTH, $urandom_range(205, 235));
		repeat (HEADER_LEN - 28) push_pixel(rand_pixel(), msg_byte_t'($urandom_range(0, 255)));
		settle();

		// Message body in random bursts; the mode is redrawn between bursts so the
		// shared byte state carries across. Finish in extract mode to see
		// the final byte flagged.
		while (codec_model.bytes_left != 0) begin
			pick_profile();
			if (codec_model.bytes_left <= 4) begin
				next_mode = MODE_EXTRACT;
			end else begin
				next_mode = logic'($urandom_range(0, 1));
			end
			write_reg(REG_MODE, ($urandom() & ~32'd1) | 32'(next_mode));
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_MESSAGE_LENGTH, $urandom());
			end
			burst = $urandom_range(1, 60);
			if (codec_model.bytes_left > 4 && burst > 8 * (codec_model.bytes_left - 4)) begin
				burst = 8 * (codec_model.bytes_left - 4);
			end
			repeat (burst) push_pixel(rand_pixel(), msg_byte_t'($urandom_range(0, 255)));
			settle();
		end

		// Message done: pixels pass through in both modes, whatever the length.
		pick_profile();
		write_reg(REG_MODE, 32'(MODE_HIDE));
		write_reg(REG_MESSAGE_LENGTH, '1);
		repeat (TAIL_ITEMS / 2) push_pixel(rand_pixel(), msg_byte_t'($urandom_range(0, 255)));
		settle();
		write_reg(REG_MODE, 32'(MODE_EXTRACT));
		write_reg(REG_MESSAGE_LENGTH, '0);
		repeat (TAIL_ITEMS / 2) push_pixel(rand_pixel(), msg_byte_t'($urandom_range(0, 255)));
		settle();

		// Give any stray result time to show up.
		repeat (8) @(negedge clk);
		if (codec_model.mismatch_count == 0 && codec_model.awaited.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[fibonacci_lsb_stego_codec.f]
+incdir+sv
sv/fls_pkg.sv
sv/fls_nearest.sv
sv/fibonacci_lsb_stego_codec.sv
sv/fls_checker.sv
sim/fibonacci_lsb_stego_codec_test.sv
